// ----- sv/sml_pkg.sv -----
// ----------------------------------------------------------------------------
// sml_pkg: shared types and constants for the member layout engine
// Widths of the item fields, offset range and the classified item that the
// front end hands to the layout engine.
// ----------------------------------------------------------------------------
package sml_pkg;

   // offset range: offsets saturate at all ones of OFFSET_BITS
   localparam int OFFSET_BITS = 32;
   localparam int VAL_W       = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
   localparam logic [VAL_W:0]         LIMIT   = (VAL_W+1)'(OFF_MAX);

   // field widths
   localparam int SIZE_W  = 32;
   localparam int ALIGN_W = 7;
   localparam int MASK_W  = 6;
   localparam int BITW_W  = 6;
   localparam int BOFF_W  = 5;

   // bitfield storage unit
   localparam int UNIT_BYTES = 4;
   localparam int UNIT_BITS  = 32;

   // queue sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH   = 4;
   localparam int OPTR_W      = $clog2(OUT_DEPTH);

   // what the layout engine does with one item
   typedef enum logic [2:0] {
      OP_SKIP,          // untyped member
      OP_BF_BREAK,      // zero-width bitfield
      OP_BF_UNION,      // bitfield of a union
      OP_BF_PACK,       // bitfield packed into a struct unit
      OP_MEMBER,        // complete ordinary member
      OP_MEMBER_NONE    // incomplete ordinary member
   } op_type;

   // classified item
   typedef struct packed {
      op_type              op;
      logic [SIZE_W-1:0]   size;
      logic [ALIGN_W-1:0]  align;
      logic [MASK_W-1:0]   mask;
      logic [BITW_W-1:0]   width;
      logic                agg_union;
      logic                last;
   } cls_type;

   // result item
   typedef struct packed {
      logic [31:0]         member_offset;
      logic [BOFF_W-1:0]   bit_pos;
      logic                placed;
      logic [31:0]         struct_size;
      logic [ALIGN_W-1:0]  struct_align;
      logic                done_res;
      logic                overflow;
   } rsp_type;

endpackage

// ----- sv/struct_member_layout.sv -----
// ----------------------------------------------------------------------------
// struct_member_layout: struct and union member layout engine
// Assigns byte and bit offsets to aggregate members in declaration order and
// reports the padded size and alignment on the last member.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake        item contents
//   req_      in          push / full      one member description
//   rsp_      out         empty / pop      offsets, placement, final size
//
// One item per cycle sustained while the result queue has room. The layout
// update takes an item from the item queue into the engine stage register,
// size padding puts its result in the result queue. Synchronous active-high
// reset clears both queues and the state. A stalled consumer fills the
// four-entry result queue, then the item queue; full rises only when the
// item queue holds four items.
//
module struct_member_layout (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_kind,
   input  logic                          req_has_type,
   input  logic [sml_pkg::SIZE_W-1:0]    req_member_size,
   input  logic [sml_pkg::ALIGN_W-1:0]   req_member_align,
   input  logic                          req_member_complete,
   input  logic [sml_pkg::BITW_W-1:0]    req_bit_width,
   input  logic                          req_union_mode,
   input  logic                          req_last,
   output logic                          empty,
   input  logic                          pop,
   output logic [31:0]                   rsp_member_offset,
   output logic [sml_pkg::BOFF_W-1:0]    rsp_bit_offset,
   output logic                          rsp_placed,
   output logic [31:0]                   rsp_struct_size,
   output logic [sml_pkg::ALIGN_W-1:0]   rsp_struct_align,
   output logic                          rsp_done_res,
   output logic                          rsp_overflow
);
   import sml_pkg::*;

   cls_type cls_w;
   cls_type q_item;
   logic    q_empty;
   logic    q_pop;
   rsp_type rsp_w;

   // classifier
   sml_front u_front (
      .req_kind            (req_kind),
      .req_has_type        (req_has_type),
      .req_member_size     (req_member_size),
      .req_member_align    (req_member_align),
      .req_member_complete (req_member_complete),
      .req_bit_width       (req_bit_width),
      .req_union_mode      (req_union_mode),
      .req_last            (req_last),
      .cls                 (cls_w)
   );

   // item queue
   sml_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (cls_w),
      .full    (full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_item (q_item)
   );

   // layout engine and result queue
   sml_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .item    (q_item),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp_w)
   );

   // result fields
   assign rsp_member_offset = rsp_w.member_offset;
   assign rsp_bit_offset    = rsp_w.bit_pos;
   assign rsp_placed        = rsp_w.placed;
   assign rsp_struct_size   = rsp_w.struct_size;
   assign rsp_struct_align  = rsp_w.struct_align;
   assign rsp_done_res      = rsp_w.done_res;
   assign rsp_overflow      = rsp_w.overflow;

endmodule

// ----- sv/sml_front.sv -----
// ----------------------------------------------------------------------------
// sml_front: member classifier
// Cleans alignment and bitfield width and decides how the member is laid out.
// ----------------------------------------------------------------------------
module sml_front (
   input  logic                          req_kind,
   input  logic                          req_has_type,
   input  logic [sml_pkg::SIZE_W-1:0]    req_member_size,
   input  logic [sml_pkg::ALIGN_W-1:0]   req_member_align,
   input  logic                          req_member_complete,
   input  logic [sml_pkg::BITW_W-1:0]    req_bit_width,
   input  logic                          req_union_mode,
   input  logic                          req_last,
   output sml_pkg::cls_type              cls
);
   import sml_pkg::*;

   logic [ALIGN_W-1:0] align_c;
   logic [BITW_W-1:0]  width_c;
   op_type             op_c;

   // round alignment down to a power of two, zero taken as one
   always_comb begin
      priority if (req_member_align[6]) begin
         align_c = 7'd64;
      end else if (req_member_align[5]) begin
         align_c = 7'd32;
      end else if (req_member_align[4]) begin
         align_c = 7'd16;
      end else if (req_member_align[3]) begin
         align_c = 7'd8;
      end else if (req_member_align[2]) begin
         align_c = 7'd4;
      end else if (req_member_align[1]) begin
         align_c = 7'd2;
      end else begin
         align_c = 7'd1;
      end
   end

   // clamp bitfield width to one unit
   assign width_c = (req_bit_width > BITW_W'(UNIT_BITS)) ? BITW_W'(UNIT_BITS) : req_bit_width;

   // classify
   always_comb begin
      priority if (!req_has_type) begin
         op_c = OP_SKIP;
      end else if (req_kind) begin
         priority if (width_c == '0) begin
            op_c = OP_BF_BREAK;
         end else if (req_union_mode) begin
            op_c = OP_BF_UNION;
         end else begin
            op_c = OP_BF_PACK;
         end
      end else if (req_member_complete) begin
         op_c = OP_MEMBER;
      end else begin
         op_c = OP_MEMBER_NONE;
      end
   end

   assign cls.op        = op_c;
   assign cls.size      = req_member_size;
   assign cls.align     = align_c;
   assign cls.mask      = MASK_W'(align_c - 7'd1);
   assign cls.width     = width_c;
   assign cls.agg_union = req_union_mode;
   assign cls.last      = req_last;

endmodule

// ----- sv/sml_queue.sv -----
// ----------------------------------------------------------------------------
// sml_queue: classified item queue
// Short FIFO between the classifier and the layout engine.
// ----------------------------------------------------------------------------
module sml_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sml_pkg::cls_type  wr_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output sml_pkg::cls_type  rd_item
);
   import sml_pkg::*;

   cls_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- sv/sml_back.sv -----
// ----------------------------------------------------------------------------
// sml_back: layout engine and result queue
// Updates the running layout state once per item, finishes the aggregate size
// on the last member and buffers results for the consumer.
// ----------------------------------------------------------------------------
module sml_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sml_pkg::cls_type  item,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output sml_pkg::rsp_type  rsp
);
   import sml_pkg::*;

   // engine stage register contents
   typedef struct packed {
      logic [OFFSET_BITS-1:0] moff;
      logic [BOFF_W-1:0]      boff;
      logic                   placed;
      logic                   last;
      logic [VAL_W-1:0]       fin_x;
      logic [ALIGN_W-1:0]     talign;
      logic [MASK_W-1:0]      tmask;
      logic                   ovf;
   } fin_type;

   // layout state
   logic [OFFSET_BITS-1:0] run_ff, run_in;
   logic [OFFSET_BITS-1:0] unit_ff, unit_in;
   logic [OFFSET_BITS-1:0] close_ff, close_in;
   logic                   close_ovf_ff, close_ovf_in;
   logic [BITW_W-1:0]      bitpos_ff, bitpos_in;
   logic                   open_ff, open_in;
   logic [ALIGN_W-1:0]     lalign_ff, lalign_in;
   logic [SIZE_W-1:0]      lsize_ff, lsize_in;
   logic                   ovf_ff, ovf_in;

   // engine stage and result queue
   fin_type                fin_ff, fin_in;
   logic                   fin_vld_ff;
   rsp_type                obuf_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]      o_wr_ff, o_rd_ff;
   logic [OPTR_W:0]        o_cnt_ff, o_cnt_in;
   logic                   o_pop;
   rsp_type                rsp_in;

   // datapath
   logic                   issue;
   logic [OFFSET_BITS-1:0] base;
   logic                   base_ovf;
   logic [VAL_W:0]         mem_sum, end_sum, u_sum, c_sum, c_trunc, f_sum, f_val;
   logic                   mem_sat, end_sat, u_sat, c_sat, f_sat;
   logic [OFFSET_BITS-1:0] aligned, end_val, u_val, c_val;
   logic [BITW_W:0]        bit_end;
   logic                   fits;

   // take an item only when its result has a guaranteed slot
   assign issue = ~q_empty
                  & ((o_cnt_ff + (OPTR_W+1)'(fin_vld_ff)) < (OPTR_W+1)'(OUT_DEPTH));
   assign q_pop = issue;

   // closing an open unit lands the offset at its precomputed end
   assign base     = open_ff ? close_ff : run_ff;
   assign base_ovf = open_ff & close_ovf_ff;

   // ordinary member: align up, then advance by the size
   always_comb begin
      mem_sum = (VAL_W+1)'(base) + (VAL_W+1)'(item.mask);
      mem_sat = mem_sum > LIMIT;
      aligned = mem_sat ? OFF_MAX : (mem_sum[OFFSET_BITS-1:0] & ~OFFSET_BITS'(item.mask));
      end_sum = (VAL_W+1)'(aligned) + (VAL_W+1)'(item.size);
      end_sat = end_sum > LIMIT;
      end_val = end_sat ? OFF_MAX : end_sum[OFFSET_BITS-1:0];
   end

   // new bitfield unit and its end offset, both from the base
   always_comb begin
      u_sum   = (VAL_W+1)'(base) + (VAL_W+1)'(UNIT_BYTES - 1);
      u_sat   = u_sum > LIMIT;
      u_val   = u_sat ? OFF_MAX
                      : (u_sum[OFFSET_BITS-1:0] & ~OFFSET_BITS'(UNIT_BYTES - 1));
      c_sum   = (VAL_W+1)'(base) + (VAL_W+1)'(2 * UNIT_BYTES - 1);
      c_trunc = c_sum & ~(VAL_W+1)'(UNIT_BYTES - 1);
      c_sat   = u_sat | (c_trunc > LIMIT);
      c_val   = c_sat ? OFF_MAX : c_trunc[OFFSET_BITS-1:0];
      bit_end = (BITW_W+1)'(bitpos_ff) + (BITW_W+1)'(item.width);
      fits    = bit_end <= (BITW_W+1)'(UNIT_BITS);
   end

   // per-member state update
   always_comb begin
      run_in       = run_ff;
      unit_in      = unit_ff;
      close_in     = close_ff;
      close_ovf_in = close_ovf_ff;
      bitpos_in    = bitpos_ff;
      open_in      = open_ff;
      lalign_in    = lalign_ff;
      lsize_in     = lsize_ff;
      ovf_in       = ovf_ff;
      fin_in.moff   = '0;
      fin_in.boff   = '0;
      fin_in.placed = 1'b0;
      unique case (item.op)
         OP_SKIP: begin
         end
         OP_BF_BREAK: begin
            if (open_ff && bitpos_ff != '0) begin
               run_in    = close_ff;
               ovf_in    = ovf_ff | close_ovf_ff;
               open_in   = 1'b0;
               bitpos_in = '0;
            end
         end
         OP_BF_UNION: begin
            fin_in.placed = 1'b1;
            if (lsize_ff < SIZE_W'(UNIT_BYTES)) lsize_in = SIZE_W'(UNIT_BYTES);
            if (lalign_ff < ALIGN_W'(UNIT_BYTES)) lalign_in = ALIGN_W'(UNIT_BYTES);
         end
         OP_BF_PACK: begin
            fin_in.placed = 1'b1;
            if (!open_ff || !fits) begin
               run_in       = u_val;
               unit_in      = u_val;
               close_in     = c_val;
               close_ovf_in = c_sat;
               ovf_in       = ovf_ff | base_ovf | u_sat;
               open_in      = 1'b1;
               bitpos_in    = item.width;
               if (lalign_ff < ALIGN_W'(UNIT_BYTES)) lalign_in = ALIGN_W'(UNIT_BYTES);
               fin_in.moff  = u_val;
            end else begin
               fin_in.moff  = unit_ff;
               fin_in.boff  = BOFF_W'(bitpos_ff);
               bitpos_in    = bit_end[BITW_W-1:0];
            end
         end
         OP_MEMBER: begin
            fin_in.placed = 1'b1;
            open_in       = 1'b0;
            bitpos_in     = '0;
            if (item.align > lalign_ff) lalign_in = item.align;
            if (item.agg_union) begin
               run_in = base;
               ovf_in = ovf_ff | base_ovf;
               if (item.size > lsize_ff) lsize_in = item.size;
            end else begin
               fin_in.moff = aligned;
               run_in      = end_val;
               ovf_in      = ovf_ff | base_ovf | mem_sat | end_sat;
            end
         end
         OP_MEMBER_NONE: begin
            run_in    = base;
            ovf_in    = ovf_ff | base_ovf;
            open_in   = 1'b0;
            bitpos_in = '0;
         end
         default: begin
         end
      endcase

      // end of aggregate: close an open unit, pick the size to pad
      fin_in.last   = item.last;
      fin_in.talign = lalign_in;
      fin_in.tmask  = MASK_W'(lalign_in - 7'd1);
      fin_in.ovf    = ovf_in | (item.last & open_in & close_ovf_in);
      if (item.agg_union) begin
         fin_in.fin_x = VAL_W'(lsize_in);
      end else if (open_in) begin
         fin_in.fin_x = VAL_W'(close_in);
      end else begin
         fin_in.fin_x = VAL_W'(run_in);
      end
   end

   // layout state registers, cleared after the last member
   always_ff @(posedge clock) begin
      if (reset || (issue && item.last)) begin
         run_ff       <= '0;
         unit_ff      <= '0;
         close_ff     <= '0;
         close_ovf_ff <= 1'b0;
         bitpos_ff    <= '0;
         open_ff      <= 1'b0;
         lalign_ff    <= ALIGN_W'(1);
         lsize_ff     <= '0;
         ovf_ff       <= 1'b0;
      end else if (issue) begin
         run_ff       <= run_in;
         unit_ff      <= unit_in;
         close_ff     <= close_in;
         close_ovf_ff <= close_ovf_in;
         bitpos_ff    <= bitpos_in;
         open_ff      <= open_in;
         lalign_ff    <= lalign_in;
         lsize_ff     <= lsize_in;
         ovf_ff       <= ovf_in;
      end
   end

   // engine stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else begin
         fin_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         fin_ff <= fin_in;
      end
   end

   // pad the total size to the aggregate alignment
   always_comb begin
      f_sum = (VAL_W+1)'(fin_ff.fin_x) + (VAL_W+1)'(fin_ff.tmask);
      f_sat = f_sum > LIMIT;
      f_val = f_sat ? LIMIT : (f_sum & ~(VAL_W+1)'(fin_ff.tmask));
      rsp_in.member_offset = 32'(fin_ff.moff);
      rsp_in.bit_pos       = fin_ff.boff;
      rsp_in.placed        = fin_ff.placed;
      rsp_in.struct_size   = fin_ff.last ? 32'(f_val) : 32'd0;
      rsp_in.struct_align  = fin_ff.last ? fin_ff.talign : ALIGN_W'(1);
      rsp_in.done_res      = fin_ff.last;
      rsp_in.overflow      = fin_ff.ovf | (fin_ff.last & f_sat);
   end

   // result queue
   assign empty    = (o_cnt_ff == '0);
   assign o_pop    = pop & ~empty;
   assign rsp      = obuf_ff[o_rd_ff];
   assign o_cnt_in = o_cnt_ff + (OPTR_W+1)'(fin_vld_ff) - (OPTR_W+1)'(o_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff  <= '0;
         o_rd_ff  <= '0;
         o_cnt_ff <= '0;
      end else begin
         if (fin_vld_ff) o_wr_ff <= o_wr_ff + 1'b1;
         if (o_pop) o_rd_ff <= o_rd_ff + 1'b1;
         o_cnt_ff <= o_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_vld_ff) begin
         obuf_ff[o_wr_ff] <= rsp_in;
      end
   end

   // checks
   a_obuf_bound: assert property (@(posedge clock) disable iff (reset)
      o_cnt_ff <= (OPTR_W+1)'(OUT_DEPTH))
      else $error("result queue over capacity");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff |-> o_cnt_ff < (OPTR_W+1)'(OUT_DEPTH))
      else $error("finished item has no result slot");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      issue && item.last |=> !open_ff && run_ff == '0 && !ovf_ff
                             && lalign_ff == ALIGN_W'(1) && lsize_ff == '0)
      else $error("layout state not cleared after last member");

   a_open_bits: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> bitpos_ff != '0 && bitpos_ff <= BITW_W'(UNIT_BITS))
      else $error("open unit with bad bit position");

   a_issue_to_fin: assert property (@(posedge clock) disable iff (reset)
      issue |=> fin_vld_ff)
      else $error("issued item lost before result queue");

endmodule
